### hw/rtl/b64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 codec package
// Shared types, character constants and alphabet mapping functions.
// ----------------------------------------------------------------------------
package b64_pkg;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic       ModeEnc   = 1'b0;
  localparam logic       ModeDec   = 1'b1;

  // One completed group: up to four result bytes, first in data[0].
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic            last;
    logic            bad;
  } burst_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] s);
    logic [7:0] w;
    w = {2'b00, s};
    if (s < 6'd26)       return w + 8'h41;
    else if (s < 6'd52)  return w + 8'h47;
    else if (s < 6'd62)  return w - 8'h04;
    else if (s == 6'd62) return 8'h2B;
    else                 return 8'h2F;
  endfunction

  function automatic sextet_t char_to_sextet(input logic [7:0] c);
    sextet_t    r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d     = c - 8'h41;
      r.ok  = 1'b1;
      r.val = d[5:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d     = c - 8'h47;
      r.ok  = 1'b1;
      r.val = d[5:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d     = c + 8'h04;
      r.ok  = 1'b1;
      r.val = d[5:0];
    end else if (c == 8'h2B) begin
      r.ok  = 1'b1;
      r.val = 6'd62;
    end else if (c == 8'h2F) begin
      r.ok  = 1'b1;
      r.val = 6'd63;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/b64_collect.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 group collector
// Gathers input items into groups and hands each finished group on as a burst.
// ----------------------------------------------------------------------------
module b64_collect (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            in_last_i,
  output logic                 burst_valid_o,
  output b64_pkg::burst_t      burst_o,
  input  wire logic            take_i
);

  logic            mode_q;
  logic [23:0]     bits_q, bits_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      pad_q, pad_d;
  logic            bad_q, bad_d;
  logic            pend_valid_q;
  b64_pkg::burst_t pend_q, burst_d;
  logic            done;
  logic            accept;

  logic [1:0]       epos;
  logic [23:0]      ebits;
  logic [23:0]      dbits;
  logic [2:0]       dn;
  logic [5:0]       v;
  b64_pkg::sextet_t sx;

  assign accept        = in_valid_i && in_ready_o;
  assign in_ready_o    = !pend_valid_q || take_i;
  assign burst_valid_o = pend_valid_q;
  assign burst_o       = pend_q;

  always_comb begin
    bits_d  = bits_q;
    cnt_d   = cnt_q;
    pad_d   = pad_q;
    bad_d   = bad_q;
    burst_d = '0;
    done    = 1'b0;
    epos    = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
    ebits   = bits_q;
    dbits   = bits_q;
    dn      = {1'b0, cnt_q} + 3'd1;
    v       = '0;
    sx      = b64_pkg::char_to_sextet(in_byte_i);
    if (mode_q == b64_pkg::ModeEnc) begin
      unique case (epos)
        2'd0:    ebits[23:16] = bits_q[23:16] | in_byte_i;
        2'd1:    ebits[15:8]  = bits_q[15:8]  | in_byte_i;
        default: ebits[7:0]   = bits_q[7:0]   | in_byte_i;
      endcase
      done              = (epos == 2'd2) || in_last_i;
      bits_d            = ebits;
      cnt_d             = epos + 2'd1;
      burst_d.data[0]   = b64_pkg::sextet_to_char(ebits[23:18]);
      burst_d.data[1]   = b64_pkg::sextet_to_char(ebits[17:12]);
      burst_d.data[2]   = (epos != 2'd0) ? b64_pkg::sextet_to_char(ebits[11:6])
                                         : b64_pkg::PadChar;
      burst_d.data[3]   = (epos == 2'd2) ? b64_pkg::sextet_to_char(ebits[5:0])
                                         : b64_pkg::PadChar;
      burst_d.cnt       = 3'd4;
      burst_d.last      = in_last_i;
      burst_d.bad       = 1'b0;
    end else begin
      if (in_byte_i == b64_pkg::PadChar) begin
        if (cnt_q == 2'd0) begin
          bad_d = 1'b1;
        end else if (pad_q == 2'd0) begin
          pad_d = cnt_q;
        end
      end else begin
        v = sx.val;
        if (!sx.ok) bad_d = 1'b1;
      end
      unique case (cnt_q)
        2'd0:    dbits[23:18] = bits_q[23:18] | v;
        2'd1:    dbits[17:12] = bits_q[17:12] | v;
        2'd2:    dbits[11:6]  = bits_q[11:6]  | v;
        default: dbits[5:0]   = bits_q[5:0]   | v;
      endcase
      done   = (cnt_q == 2'd3) || in_last_i;
      bits_d = dbits;
      cnt_d  = dn[1:0];
      if (cnt_q != 2'd3 && pad_d == 2'd0) pad_d = dn[1:0];
      burst_d.data[0] = dbits[23:16];
      burst_d.data[1] = dbits[15:8];
      burst_d.data[2] = dbits[7:0];
      burst_d.data[3] = 8'h00;
      priority if (pad_d == 2'd0) burst_d.cnt = 3'd3;
      else if (pad_d == 2'd3)     burst_d.cnt = 3'd2;
      else                        burst_d.cnt = 3'd1;
      burst_d.last = in_last_i;
      burst_d.bad  = bad_d;
      if (!done) pad_d = (in_byte_i == b64_pkg::PadChar && cnt_q != 2'd0 &&
                          pad_q == 2'd0) ? cnt_q : pad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= b64_pkg::ModeEnc;
      bits_q       <= '0;
      cnt_q        <= '0;
      pad_q        <= '0;
      bad_q        <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
        bits_q <= '0;
        cnt_q  <= '0;
        pad_q  <= '0;
        bad_q  <= 1'b0;
      end else if (accept) begin
        if (done) begin
          bits_q <= '0;
          cnt_q  <= '0;
          pad_q  <= '0;
          bad_q  <= 1'b0;
        end else begin
          bits_q <= bits_d;
          cnt_q  <= cnt_d;
          pad_q  <= pad_d;
          bad_q  <= bad_d;
        end
      end
      if (accept && done) begin
        pend_valid_q <= 1'b1;
      end else if (take_i) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && done) begin
      pend_q <= burst_d;
    end
  end

`ifndef SYNTH
  a_enc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == b64_pkg::ModeEnc) |-> (cnt_q != 2'd3))
    else $error("encode group count out of range");
  a_burst_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (pend_q.cnt != 3'd0 && pend_q.cnt <= 3'd4))
    else $error("burst length out of range");
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && !take_i) |=> (pend_valid_q && $stable(pend_q)))
    else $error("pending burst lost");
`endif

endmodule
`default_nettype wire

### hw/rtl/b64_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 result emitter
// Holds one burst and sends its bytes out one transaction per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module b64_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            burst_valid_i,
  input  wire b64_pkg::burst_t burst_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic                 out_bad_o
);

  logic            valid_q;
  logic [3:0][7:0] data_q;
  logic [2:0]      rem_q;
  logic            last_q;
  logic            bad_q;
  logic            xfer;
  logic            final_x;

  assign xfer        = valid_q && out_ready_i;
  assign final_x     = xfer && (rem_q == 3'd1);
  assign take_o      = burst_valid_i && (!valid_q || final_x);
  assign out_valid_o = valid_q;
  assign out_byte_o  = data_q[0];
  assign out_last_o  = last_q && (rem_q == 3'd1);
  assign out_bad_o   = bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
    end else if (take_o) begin
      valid_q <= 1'b1;
      rem_q   <= burst_i.cnt;
    end else if (xfer) begin
      valid_q <= (rem_q != 3'd1);
      rem_q   <= rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      data_q <= burst_i.data;
      last_q <= burst_i.last;
      bad_q  <= burst_i.bad;
    end else if (xfer) begin
      data_q <= {8'h00, data_q[3:1]};
    end
  end

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rem_q != 3'd0 && rem_q <= 3'd4))
    else $error("remaining count out of range");
  a_rem_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && rem_q > 3'd1) |=> (valid_q && rem_q == $past(rem_q) - 3'd1))
    else $error("burst cut short");
  a_take_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |-> (!valid_q || final_x))
    else $error("burst overwritten");
`endif

endmodule
`default_nettype wire

### hw/rtl/base64_codec_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Base64 codec
// Base64 encoder/decoder with a mode register and stream ports.
// ----------------------------------------------------------------------------
// A group's first result passes the collector's burst register, then the emitter's register.
// Output: one result per cycle while m_axis_tready is high; a burst holds 4 (encode) or 1-3 bytes.
// Input: one item per cycle while the burst register is free; in encode the input
// waits on the output, which sends one result at a time.
// Reset clears mode to encode and drops any partial group and pending results.
module base64_codec_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,   // mode: 0 encode, 1 decode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic             m_axis_tlast,
  output logic             m_axis_tuser   // [0] bad_char
);

  logic            burst_valid;
  b64_pkg::burst_t burst;
  logic            take;

  b64_collect u_collect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .burst_valid_o(burst_valid),
    .burst_o      (burst),
    .take_i       (take)
  );

  b64_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .burst_valid_i(burst_valid),
    .burst_i      (burst),
    .take_o       (take),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_bad_o    (m_axis_tuser)
  );

endmodule
`default_nettype wire
